[design/bdws_pkg.sv]
`timescale 1ns / 1ps

package bdws_pkg;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 5;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_DEL_FRONT = 3'd2,
        MODE_DEL_BACK  = 3'd3,
        MODE_SEARCH    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } t_state;

    // Move applied to the whole row of cells
    typedef enum logic [2:0] {
        ROW_HOLD,
        ROW_PUSH_FRONT,
        ROW_PUSH_BACK,
        ROW_POP_FRONT,
        ROW_ROTATE
    } t_row_cmd;

    // Source a single cell takes its next word from
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_FROM_HEAD
    } t_cell_op;

endpackage

[design/bounded_deque_with_search_unit.sv]
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// -------   -------------------------------------------  ----------------------------
// command   i_mode, i_value                              word taken when start & !busy
// result    o_status, o_found_position, o_occupancy      o_strobe high for one cycle
//
// For inserts, deletes, no-op codes and a search of an empty deque, the result word
// strobes on the cycle after the command, and busy stays low, so a new command may
// follow at once.
// A search of a non-empty deque holds busy high while the row of cells rotates by one
// per cycle past the head compare, once per occupied cell, so after a full turn the
// order is restored. The result strobes on the cycle after the last compare, with busy
// already low.
// Reset (i_rst_n low, synchronous) empties the deque; cell contents are not cleared.
// The receiver cannot stall: every result word is taken in its strobe cycle.

module bounded_deque_with_search_unit
    import bdws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_mode,
    input  logic signed [WORD_W-1:0]  i_value,
    output logic                      o_strobe,
    output logic [1:0]                o_status,
    output logic [FIELD_W-1:0]        o_found_position,
    output logic [FIELD_W-1:0]        o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    // Row of cells: cell 0 holds the front word
    logic signed [WORD_W-1:0] w_cell [DEPTH];
    t_cell_op                 w_op   [DEPTH];
    t_row_cmd                 w_row_cmd;

    t_state                   r_state,  n_state;
    logic [CW-1:0]            r_count,  n_count;
    logic signed [WORD_W-1:0] r_key,    n_key;
    logic [CW-1:0]            r_step,   n_step;
    logic                     r_found,  n_found;
    logic [CW-1:0]            r_pos,    n_pos;
    logic                     r_strobe, n_strobe;
    t_status                  r_status, n_status;
    logic [CW-1:0]            r_out_pos, n_out_pos;
    logic [CW-1:0]            r_out_occ, n_out_occ;

    logic                     w_full;
    logic                     w_empty;
    logic                     w_hit;
    logic [CW-1:0]            w_last;
    logic [CW-1:0]            w_step_inc;

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_last     = r_count - CW'(1);
    assign w_step_inc = r_step + CW'(1);
    // first match only: later hits are ignored once one is latched
    assign w_hit      = !r_found && (w_cell[0] == r_key);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Search and result payload
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_step    <= n_step;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_out_pos <= n_out_pos;
        r_out_occ <= n_out_occ;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_step    = r_step;
        n_found   = r_found;
        n_pos     = r_pos;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_out_pos = r_out_pos;
        n_out_occ = r_out_occ;
        w_row_cmd = ROW_HOLD;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_strobe  = 1'b1;
                    n_status  = STAT_OK;
                    n_out_pos = '0;
                    n_out_occ = r_count;
                    case (i_mode)
                        MODE_INS_FRONT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_row_cmd = ROW_PUSH_FRONT;
                                n_count   = r_count + CW'(1);
                                n_out_occ = r_count + CW'(1);
                            end
                        end
                        MODE_INS_BACK: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_row_cmd = ROW_PUSH_BACK;
                                n_count   = r_count + CW'(1);
                                n_out_occ = r_count + CW'(1);
                            end
                        end
                        MODE_DEL_FRONT: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                w_row_cmd = ROW_POP_FRONT;
                                n_count   = w_last;
                                n_out_occ = w_last;
                            end
                        end
                        MODE_DEL_BACK: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // drop the back word by shrinking the count
                                n_count   = w_last;
                                n_out_occ = w_last;
                            end
                        end
                        MODE_SEARCH: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // hold the result until the walk ends
                                n_strobe = 1'b0;
                                n_state  = ST_SEARCH;
                                n_key    = i_value;
                                n_step   = '0;
                                n_found  = 1'b0;
                                n_pos    = '0;
                            end
                        end
                        default: begin
                            // unused codes: no-op, status ok
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // compare the head, then advance the ring by one
                w_row_cmd = ROW_ROTATE;
                n_step    = w_step_inc;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_pos   = w_step_inc;
                end
                if (r_step == w_last) begin
                    n_state   = ST_IDLE;
                    n_strobe  = 1'b1;
                    n_out_occ = r_count;
                    if (r_found || w_hit) begin
                        n_status  = STAT_OK;
                        n_out_pos = w_hit ? w_step_inc : r_pos;
                    end else begin
                        n_status  = STAT_NOT_FOUND;
                        n_out_pos = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Cell row
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);

            logic signed [WORD_W-1:0] w_prev;
            logic signed [WORD_W-1:0] w_next;

            if (g == 0) begin : g_first
                assign w_prev = w_cell[g];
            end else begin : g_mid_prev
                assign w_prev = w_cell[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_next = w_cell[g];
            end else begin : g_mid_next
                assign w_next = w_cell[g+1];
            end

            always_comb begin
                case (w_row_cmd)
                    ROW_PUSH_FRONT: w_op[g] = (g == 0) ? CELL_LOAD : CELL_FROM_PREV;
                    ROW_PUSH_BACK:  w_op[g] = (IDX == r_count) ? CELL_LOAD : CELL_HOLD;
                    ROW_POP_FRONT:  w_op[g] = CELL_FROM_NEXT;
                    ROW_ROTATE: begin
                        // rotate only across the occupied span
                        if (IDX == w_last) begin
                            w_op[g] = CELL_FROM_HEAD;
                        end else if (IDX < w_last) begin
                            w_op[g] = CELL_FROM_NEXT;
                        end else begin
                            w_op[g] = CELL_HOLD;
                        end
                    end
                    default:        w_op[g] = CELL_HOLD;
                endcase
            end

            bdws_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op[g]),
                .i_load (i_value),
                .i_prev (w_prev),
                .i_next (w_next),
                .i_head (w_cell[0]),
                .o_data (w_cell[g])
            );
        end
    endgenerate

    // Outputs: mask counts into the 5-bit fields
    logic [CW+FIELD_W-1:0] w_pos_ext;
    logic [CW+FIELD_W-1:0] w_occ_ext;

    assign w_pos_ext = {{FIELD_W{1'b0}}, r_out_pos};
    assign w_occ_ext = {{FIELD_W{1'b0}}, r_out_occ};

    assign busy             = (r_state == ST_SEARCH);
    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_found_position = w_pos_ext[FIELD_W-1:0];
    assign o_occupancy      = w_occ_ext[FIELD_W-1:0];

endmodule

[design/bdws_cell.sv]
`timescale 1ns / 1ps

module bdws_cell
    import bdws_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic signed [WORD_W-1:0] i_load,
    input  logic signed [WORD_W-1:0] i_prev,
    input  logic signed [WORD_W-1:0] i_next,
    input  logic signed [WORD_W-1:0] i_head,
    output logic signed [WORD_W-1:0] o_data
);

    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_HOLD:      n_data = r_data;
            CELL_LOAD:      n_data = i_load;
            CELL_FROM_PREV: n_data = i_prev;
            CELL_FROM_NEXT: n_data = i_next;
            CELL_FROM_HEAD: n_data = i_head;
            default:        n_data = r_data;
        endcase
    end

    // payload only: no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
